// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILFF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, disabled during reset
`define ILFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: rtl/core/ilff_pkg.sv
// types, codes and helper functions of the first-fit allocator
`default_nettype none
package ilff_pkg;

    localparam int CHUNK_W     = 13;
    localparam int BYTES_W     = 14;
    localparam int ADDR_W      = 14;
    localparam int STAT_W      = 2;
    localparam int NEED_W      = 13;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 16;

    localparam int MIN_BLOCK_WORDS = 4;
    localparam int ALIGN_BYTES     = 16;
    localparam int TAG_BYTES       = 8;
    localparam int PROLOGUE_WORD   = 2;
    localparam int FIRST_BLOCK     = 3;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd1024;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_ALLOC = 2'd0,
        STAT_FREED = 2'd1,
        STAT_ZERO  = 2'd2,
        STAT_OOM   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_PRO,
        ST_INIT_HDR,
        ST_DISPATCH,
        ST_WALK,
        ST_GROW,
        ST_GROW_FTR,
        ST_GROW_EPI,
        ST_MERGE_PREV,
        ST_MERGE_NEXT,
        ST_MERGE_DECIDE,
        ST_MERGE_PRV,
        ST_MERGE_HDR,
        ST_MERGE_FTR,
        ST_PLACE,
        ST_PLACE_FTR,
        ST_SPLIT_HDR,
        ST_SPLIT_FTR,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic                func;
        logic [BYTES_W-1:0]  request_bytes;
        logic [ADDR_W-1:0]   payload_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        status_t           status;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    // block words for a payload: (bytes + tags) rounded up to the alignment
    function automatic logic [NEED_W-1:0] need_words(input logic [BYTES_W-1:0] bytes);
        logic [BYTES_W:0]  sum;
        logic [NEED_W-1:0] w;
        sum = {1'b0, bytes} + (BYTES_W+1)'(TAG_BYTES + ALIGN_BYTES - 1);
        w   = {sum[BYTES_W:4], 2'b00};
        if (w < NEED_W'(MIN_BLOCK_WORDS))
            w = NEED_W'(MIN_BLOCK_WORDS);
        return w;
    endfunction

    // chunk rounded down to whole blocks, at least one minimum block
    function automatic logic [CHUNK_W-1:0] eff_chunk(input logic [CHUNK_W-1:0] c);
        logic [CHUNK_W-1:0] r;
        r = {c[CHUNK_W-1:2], 2'b00};
        if (r < CHUNK_W'(MIN_BLOCK_WORDS))
            r = CHUNK_W'(MIN_BLOCK_WORDS);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/implicit_list_first_fit_allocator.sv
// top level of the first-fit boundary-tag heap allocator
//
// first-fit heap allocator over one tag memory of HEAP_WORDS words, one read
// and one write port, read data registered, there in the cycle after the
// address. an item is an allocate or a free; each item gives exactly one
// result item. the block works on one item at a time: an allocate reads one
// block header per step of the first-fit walk, then places the block, and
// writes the rest as a free block when the block is split; when no block fits
// it grows the break and merges the new chunk with a free last block. a free
// walks to its block, frees it when it is in use, checks both neighbors and
// merges with a free neighbor. a null free or a zero-size allocate skips the
// walk. the very first item also lays down the fences and the first chunk. the
// walk is bound by the single memory read port, one header per cycle. the
// result sits in an output register, so the next item is taken while the last
// result still waits. chunk_words may only be written while the block is idle.
`default_nettype none
module implicit_list_first_fit_allocator
    import ilff_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // request_bytes[13:0], payload_addr[27:14]
    input  wire logic                  s_axis_tuser,  // func
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // result_addr[13:0]
    output logic [STAT_W-1:0]          m_axis_tuser,  // status
    // chunk_words register
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CHUNK_W-1:0]    cfg_data
);

    logic [CHUNK_W-1:0] chunk_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    eng_stat_t          eng_stat;
    res_t               eng_res;
    req_t               eng_req;
    logic               start, res_take;

    // config register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_reg <= CHUNK_RESET;
        else if (cfg_valid && cfg_ready)
            chunk_reg <= cfg_data;
    end

    // request side: taken whenever the sequencer is idle
    assign s_axis_tready         = eng_stat.idle;
    assign start                 = s_axis_tvalid && s_axis_tready;
    assign eng_req.func          = s_axis_tuser;
    assign eng_req.request_bytes = s_axis_tdata[BYTES_W-1:0];
    assign eng_req.payload_addr  = s_axis_tdata[BYTES_W+ADDR_W-1:BYTES_W];

    ilff_engine #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (eng_req),
        .chunk    (eff_chunk(chunk_reg)),
        .res_take (res_take),
        .stat     (eng_stat),
        .res      (eng_res)
    );

    // output register parts the sequencer from the result stream
    assign res_take = eng_stat.done && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= eng_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_reg.result_addr);
    assign m_axis_tuser  = out_reg.status;

endmodule
`default_nettype wire

// File: rtl/core/ilff_engine.sv
// tag memory and the sequencer that walks, grows, merges and places blocks
`default_nettype none
module ilff_engine
    import ilff_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire req_t               req,
    input  wire logic [CHUNK_W-1:0] chunk,
    input  wire logic               res_take,
    output eng_stat_t               stat,
    output res_t                    res
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = AW + 1;
    localparam int TW = SW + 1;
    localparam int PW = AW + 2;
    localparam logic [PW-1:0] HEAP_P  = PW'(HEAP_WORDS);
    localparam logic [PW-1:0] FIRST_P = PW'(FIRST_BLOCK);
    localparam logic [TW-1:0] FENCE   = {1'b1, {SW{1'b0}}};

    eng_state_t state_reg, state_next, after_merge;

    logic              func_reg, func_next;
    logic [BYTES_W-1:0] req_reg, req_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PW-1:0]     need_reg, need_next;
    logic              init_reg, init_next;
    logic              ready_reg, ready_next;
    logic [PW-1:0]     blk_reg, blk_next;
    logic [PW-1:0]     size_reg, size_next;
    logic [PW-1:0]     nsize_reg, nsize_next;
    logic [PW-1:0]     psize_reg, psize_next;
    logic              pused_reg, pused_next;
    logic              nused_reg, nused_next;
    logic              split_reg, split_next;
    logic [PW-1:0]     words_reg, words_next;
    logic [PW-1:0]     break_reg, break_next;
    status_t           stat_reg, stat_next;
    logic [ADDR_W-1:0] raddr_res_reg, raddr_res_next;

    // tag memory
    logic [TW-1:0] mem [HEAP_WORDS];
    logic          we, re;
    logic [PW-1:0] waddr, raddr;
    logic [TW-1:0] wdata;
    logic [TW-1:0] rdata_reg;
    logic          oob_reg;

    always_ff @(posedge clk)
    begin
        if (we && waddr < HEAP_P)
            mem[waddr[AW-1:0]] <= wdata;
        if (re && raddr < HEAP_P)
            rdata_reg <= mem[raddr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oob_reg <= 1'b0;
        else if (re)
            oob_reg <= (raddr >= HEAP_P);
    end

    // past the store reads as a fence
    logic          tag_used;
    logic [PW-1:0] tag_size;
    assign tag_used = oob_reg | rdata_reg[SW];
    assign tag_size = oob_reg ? '0 : {1'b0, rdata_reg[SW-1:0]};

    logic          walk_end, walk_hit, walk_fit, grow_fit, do_split;
    logic [PW-1:0] chunk_p, grow_words, rem;
    logic [PW-1:0] blk_inc;
    logic [PW:0]   grow_sum;

    assign chunk_p    = PW'(chunk);
    assign grow_words = (need_reg > chunk_p) ? need_reg : chunk_p;
    assign walk_end   = (tag_size == '0);
    assign blk_inc    = blk_reg + PW'(1);
    assign walk_hit   = ({blk_inc, 2'b00} == (PW+2)'(addr_reg));
    assign walk_fit   = !tag_used && (need_reg <= tag_size);
    assign grow_sum   = {1'b0, break_reg} + {1'b0, words_reg};
    assign grow_fit   = (grow_sum <= {1'b0, HEAP_P});
    assign rem        = size_reg - need_reg;
    assign do_split   = (rem >= PW'(MIN_BLOCK_WORDS));

    function automatic logic [TW-1:0] mk_tag(input logic used, input logic [PW-1:0] sz);
        return {used, sz[SW-1:0]};
    endfunction

    always_comb
    begin
        if (init_reg)
            after_merge = ST_DISPATCH;
        else if (func_reg == FUNC_FREE)
            after_merge = ST_DONE;
        else
            after_merge = ST_PLACE;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ready_reg ? ST_DISPATCH : ST_INIT_PRO;
            ST_INIT_PRO:  state_next = ST_INIT_HDR;
            ST_INIT_HDR:  state_next = ST_GROW;
            ST_DISPATCH:
                if (func_reg == FUNC_FREE)
                    state_next = (addr_reg == '0) ? ST_DONE : ST_WALK;
                else
                    state_next = (req_reg == '0) ? ST_DONE : ST_WALK;
            ST_WALK:
                if (walk_end)
                    state_next = (func_reg == FUNC_FREE) ? ST_DONE : ST_GROW;
                else if (func_reg == FUNC_FREE)
                begin
                    if (walk_hit)
                        state_next = tag_used ? ST_GROW_FTR : ST_DONE;
                end
                else if (walk_fit)
                    state_next = ST_PLACE;
            ST_GROW:
                if (grow_fit)
                    state_next = ST_GROW_FTR;
                else
                    state_next = init_reg ? ST_DISPATCH : ST_DONE;
            ST_GROW_FTR:
                state_next = (func_reg == FUNC_FREE && !init_reg) ? ST_MERGE_PREV
                                                                 : ST_GROW_EPI;
            ST_GROW_EPI:     state_next = ST_MERGE_PREV;
            ST_MERGE_PREV:   state_next = ST_MERGE_NEXT;
            ST_MERGE_NEXT:   state_next = ST_MERGE_DECIDE;
            ST_MERGE_DECIDE:
                if (pused_reg && tag_used)
                    state_next = after_merge;
                else if (pused_reg)
                    state_next = ST_MERGE_HDR;
                else
                    state_next = ST_MERGE_PRV;
            ST_MERGE_PRV:    state_next = ST_MERGE_HDR;
            ST_MERGE_HDR:    state_next = ST_MERGE_FTR;
            ST_MERGE_FTR:    state_next = after_merge;
            ST_PLACE:        state_next = ST_PLACE_FTR;
            ST_PLACE_FTR:    state_next = split_reg ? ST_SPLIT_HDR : ST_DONE;
            ST_SPLIT_HDR:    state_next = ST_SPLIT_FTR;
            ST_SPLIT_FTR:    state_next = ST_DONE;
            ST_DONE:
                if (res_take)
                    state_next = ST_IDLE;
            default:         state_next = ST_IDLE;
        endcase
    end

    // memory controls and datapath
    always_comb
    begin
        func_next      = func_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        need_next      = need_reg;
        init_next      = init_reg;
        ready_next     = ready_reg;
        blk_next       = blk_reg;
        size_next      = size_reg;
        nsize_next     = nsize_reg;
        psize_next     = psize_reg;
        pused_next     = pused_reg;
        nused_next     = nused_reg;
        split_next     = split_reg;
        words_next     = words_reg;
        break_next     = break_reg;
        stat_next      = stat_reg;
        raddr_res_next = raddr_res_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    func_next      = req.func;
                    req_next       = req.request_bytes;
                    addr_next      = req.payload_addr;
                    need_next      = PW'(need_words(req.request_bytes));
                    init_next      = !ready_reg;
                    stat_next      = STAT_FREED;
                    raddr_res_next = '0;
                end
            ST_INIT_PRO:
            begin
                we    = 1'b1;
                waddr = PW'(PROLOGUE_WORD);
                wdata = FENCE;
            end
            ST_INIT_HDR:
            begin
                we         = 1'b1;
                waddr      = FIRST_P;
                wdata      = FENCE;
                ready_next = 1'b1;
                words_next = chunk_p;
            end
            ST_DISPATCH:
            begin
                init_next = 1'b0;
                if (func_reg == FUNC_ALLOC && req_reg == '0)
                    stat_next = STAT_ZERO;
                else if (func_reg == FUNC_ALLOC || addr_reg != '0)
                begin
                    re       = 1'b1;
                    raddr    = FIRST_P;
                    blk_next = FIRST_P;
                end
            end
            ST_WALK:
                if (walk_end)
                begin
                    words_next = grow_words;
                end
                else if (func_reg == FUNC_FREE && walk_hit)
                begin
                    // free the header now, the footer follows
                    if (tag_used)
                    begin
                        we        = 1'b1;
                        waddr     = blk_reg;
                        wdata     = mk_tag(1'b0, tag_size);
                        size_next = tag_size;
                    end
                end
                else if (func_reg == FUNC_ALLOC && walk_fit)
                    size_next = tag_size;
                else
                begin
                    re       = 1'b1;
                    raddr    = blk_reg + tag_size;
                    blk_next = blk_reg + tag_size;
                end
            ST_GROW:
                if (!grow_fit)
                begin
                    if (!init_reg)
                        stat_next = STAT_OOM;
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = break_reg - PW'(1);
                    wdata     = mk_tag(1'b0, words_reg);
                    blk_next  = break_reg - PW'(1);
                    size_next = words_reg;
                end
            ST_GROW_FTR:
            begin
                we    = 1'b1;
                waddr = blk_reg + size_reg - PW'(1);
                wdata = mk_tag(1'b0, size_reg);
            end
            ST_GROW_EPI:
            begin
                we         = 1'b1;
                waddr      = blk_reg + size_reg;
                wdata      = FENCE;
                break_next = break_reg + size_reg;
            end
            ST_MERGE_PREV:
            begin
                re    = 1'b1;
                raddr = blk_reg - PW'(1);
            end
            ST_MERGE_NEXT:
            begin
                pused_next = tag_used;
                psize_next = tag_size;
                re         = 1'b1;
                raddr      = blk_reg + size_reg;
            end
            ST_MERGE_DECIDE:
                if (pused_reg && !tag_used)
                    size_next = size_reg + tag_size;
                else if (!pused_reg)
                begin
                    nused_next = tag_used;
                    nsize_next = tag_size;
                    blk_next   = blk_reg - psize_reg;
                    re         = 1'b1;
                    raddr      = blk_reg - psize_reg;
                end
            ST_MERGE_PRV:
                size_next = size_reg + tag_size + (nused_reg ? '0 : nsize_reg);
            ST_MERGE_HDR:
            begin
                we    = 1'b1;
                waddr = blk_reg;
                wdata = mk_tag(1'b0, size_reg);
            end
            ST_MERGE_FTR:
            begin
                we    = 1'b1;
                waddr = blk_reg + size_reg - PW'(1);
                wdata = mk_tag(1'b0, size_reg);
            end
            ST_PLACE:
            begin
                we             = 1'b1;
                waddr          = blk_reg;
                wdata          = mk_tag(1'b1, do_split ? need_reg : size_reg);
                size_next      = do_split ? need_reg : size_reg;
                nsize_next     = rem;
                split_next     = do_split;
                stat_next      = STAT_ALLOC;
                raddr_res_next = {blk_inc[ADDR_W-3:0], 2'b00};
            end
            ST_PLACE_FTR:
            begin
                we    = 1'b1;
                waddr = blk_reg + size_reg - PW'(1);
                wdata = mk_tag(1'b1, size_reg);
            end
            ST_SPLIT_HDR:
            begin
                we    = 1'b1;
                waddr = blk_reg + size_reg;
                wdata = mk_tag(1'b0, nsize_reg);
            end
            ST_SPLIT_FTR:
            begin
                we    = 1'b1;
                waddr = blk_reg + size_reg + nsize_reg - PW'(1);
                wdata = mk_tag(1'b0, nsize_reg);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            init_reg  <= 1'b0;
            ready_reg <= 1'b0;
            break_reg <= PW'(4);
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            ready_reg <= ready_next;
            break_reg <= break_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        need_reg      <= need_next;
        blk_reg       <= blk_next;
        size_reg      <= size_next;
        nsize_reg     <= nsize_next;
        psize_reg     <= psize_next;
        pused_reg     <= pused_next;
        nused_reg     <= nused_next;
        split_reg     <= split_next;
        words_reg     <= words_next;
        stat_reg      <= stat_next;
        raddr_res_reg <= raddr_res_next;
    end

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.done       = (state_reg == ST_DONE);
    assign res.result_addr = raddr_res_reg;
    assign res.status      = stat_reg;

endmodule
`default_nettype wire

// File: rtl/core/ilff_checker.sv
// port-level checks of the allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ilff_checker
    import ilff_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [STAT_W-1:0]     m_axis_tuser
);

    // a granted payload is aligned
    `ILFF_ASSERT_NOW(a_align, clk, rst_n, m_axis_tvalid && m_axis_tuser == STAT_ALLOC,
        m_axis_tdata[3:0] == 4'd0)

    // anything but a grant carries a null address
    `ILFF_ASSERT_NOW(a_null, clk, rst_n, m_axis_tvalid && m_axis_tuser != STAT_ALLOC,
        m_axis_tdata == '0)

    // a taken item keeps the sequencer busy on the next cycle
    `ILFF_ASSERT_NEXT(a_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a stalled result holds
    `ILFF_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind implicit_list_first_fit_allocator ilff_checker u_ilff_checker (.*);
`default_nettype wire

// File: tb/sv/tb.sv
// testbench of the first-fit boundary-tag heap allocator
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import ilff_pkg::*;

    localparam int HEAP_WORDS = 4096;
    localparam int unsigned TAG_USED = 32'h8000_0000;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CHUNK_W-1:0] cfg_data = '0;

    always #1 clk = ~clk;

    implicit_list_first_fit_allocator #(.HEAP_WORDS(HEAP_WORDS)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // shadow heap: bit 31 in-use, low bits size in words
    int unsigned heap_tags [HEAP_WORDS];
    int unsigned brk_words;
    bit          heap_up;
    logic [CHUNK_W-1:0] chunk_reg;
    res_t        expected_results[$];
    int unsigned live_blocks[$];   // payload addresses handed out
    int          send_idle_pct, recv_idle_pct;
    bit          failed;
    longint      cycle_count;

    function automatic int unsigned tag_rd(int unsigned i);
        return i < HEAP_WORDS ? heap_tags[i] : TAG_USED;
    endfunction

    function automatic int unsigned size_of(int unsigned i);
        return tag_rd(i) & 32'h7fff_ffff;
    endfunction

    function automatic bit used_of(int unsigned i);
        return (tag_rd(i) & TAG_USED) != 0;
    endfunction

    function automatic void tag_wr(int unsigned i, int unsigned v);
        if (i < HEAP_WORDS)
            heap_tags[i] = v;
    endfunction

    function automatic void set_block(int unsigned b, int unsigned sz, bit used);
        int unsigned t;
        t = sz | (used ? TAG_USED : 0);
        tag_wr(b, t);
        tag_wr(b + sz - 1, t);
    endfunction

    // join a free block with free neighbors, give the resulting block
    function automatic int unsigned coalesce(int unsigned b);
        int unsigned sz, nx, pv, total;
        bit pu, nu;
        sz = size_of(b);
        nx = b + sz;
        pu = used_of(b - 1);
        nu = used_of(nx);
        if (pu && nu)
            return b;
        if (pu)
        begin
            set_block(b, sz + size_of(nx), 1'b0);
            return b;
        end
        pv = b - size_of(b - 1);
        total = sz + size_of(pv);
        if (!nu)
            total += size_of(nx);
        set_block(pv, total, 1'b0);
        return pv;
    endfunction

    function automatic bit raise_break(int unsigned words, output int unsigned blk);
        int unsigned b;
        blk = 0;
        if (brk_words + words > HEAP_WORDS)
            return 1'b0;
        b = brk_words - 1;
        set_block(b, words, 1'b0);
        tag_wr(b + words, TAG_USED);
        brk_words += words;
        blk = coalesce(b);
        return 1'b1;
    endfunction

    function automatic int unsigned chunk_eff();
        int unsigned c;
        c = chunk_reg & ~32'd3;
        return c < MIN_BLOCK_WORDS ? MIN_BLOCK_WORDS : c;
    endfunction

    function automatic res_t predict_heap_op(req_t r);
        res_t o;
        int unsigned b, need, words;
        bit found;
        o.result_addr = '0;
        o.status = STAT_FREED;
        if (!heap_up)
        begin
            tag_wr(PROLOGUE_WORD, TAG_USED);
            tag_wr(FIRST_BLOCK, TAG_USED);
            heap_up = 1'b1;
            void'(raise_break(chunk_eff(), b));
        end
        if (r.func == FUNC_FREE)
        begin
            if (r.payload_addr == 0)
                return o;
            for (b = FIRST_BLOCK; b < HEAP_WORDS && size_of(b) > 0; b += size_of(b))
                if ((b + 1) * 4 == r.payload_addr)
                begin
                    if (used_of(b))
                    begin
                        set_block(b, size_of(b), 1'b0);
                        void'(coalesce(b));
                    end
                    break;
                end
            return o;
        end
        if (r.request_bytes == 0)
        begin
            o.status = STAT_ZERO;
            return o;
        end
        need = ((r.request_bytes + TAG_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * 4;
        if (need < MIN_BLOCK_WORDS)
            need = MIN_BLOCK_WORDS;
        found = 1'b0;
        for (b = FIRST_BLOCK; b < HEAP_WORDS && size_of(b) > 0; b += size_of(b))
            if (!used_of(b) && need <= size_of(b))
            begin
                found = 1'b1;
                break;
            end
        if (!found)
        begin
            words = chunk_eff();
            if (need > words)
                words = need;
            if (!raise_break(words, b))
            begin
                o.status = STAT_OOM;
                return o;
            end
        end
        // place with split when the rest still holds a minimum block
        words = size_of(b);
        if (words - need >= MIN_BLOCK_WORDS)
        begin
            set_block(b, need, 1'b1);
            set_block(b + need, words - need, 1'b0);
        end
        else
            set_block(b, words, 1'b1);
        o.result_addr = ADDR_W'((b + 1) * 4);
        o.status = STAT_ALLOC;
        return o;
    endfunction

    // send one request item, predicting its result at acceptance
    task automatic send_op(logic f, int unsigned bytes, int unsigned addr);
        req_t r;
        res_t e;
        r.func = f;
        r.request_bytes = BYTES_W'(bytes);
        r.payload_addr = ADDR_W'(addr);
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {4'd0, r.payload_addr, r.request_bytes};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        e = predict_heap_op(r);
        expected_results.push_back(e);
        if (f == FUNC_ALLOC && e.status == STAT_ALLOC)
            live_blocks.push_back(e.result_addr);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic alloc_op(int unsigned bytes);
        send_op(FUNC_ALLOC, bytes, $urandom_range(16383));
    endtask

    task automatic free_op(int unsigned addr);
        send_op(FUNC_FREE, $urandom_range(16383), addr);
    endtask

    // free a random handed-out block
    task automatic free_live();
        int k;
        if (live_blocks.size() == 0)
            return;
        k = $urandom_range(live_blocks.size() - 1);
        free_op(live_blocks[k]);
        live_blocks.delete(k);
    endtask

    // wait for all results and let the engine settle
    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_chunk(int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= CHUNK_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        chunk_reg = CHUNK_W'(v);
        cfg_valid <= 1'b0;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result addr %0d status %0d", $time,
                             m_axis_tdata[ADDR_W-1:0], m_axis_tuser);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (m_axis_tdata[ADDR_W-1:0] !== e.result_addr)
                    begin
                        $display("%0t result_addr expected %0d actual %0d", $time,
                                 e.result_addr, m_axis_tdata[ADDR_W-1:0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser !== e.status)
                    begin
                        $display("%0t status expected %0d actual %0d", $time,
                                 e.status, m_axis_tuser);
                        failed = 1'b1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // first request sets up the heap; null free, zero size, extremes
    task automatic test_directed();
        free_op(0);
        alloc_op(0);
        alloc_op(1);
        alloc_op(8);
        alloc_op(9);
        alloc_op(16383);
        alloc_op(24);
        alloc_op(100);
        free_op(16383);
        free_op(live_blocks[0]);
        free_op(live_blocks[0]);   // double free is ignored
        live_blocks.delete(0);
        free_op(12);               // not a payload
        free_live();
        free_live();
        alloc_op(40);
        alloc_op(16383);
        alloc_op(16383);           // heap exhausted
        while (live_blocks.size() != 0)
            free_live();
        alloc_op(5000);
    endtask

    // random mix of allocates and frees, mostly small sizes
    task automatic test_random(int n);
        int unsigned p;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            if (p < 45)
                alloc_op(($urandom_range(9) == 0) ? $urandom_range(16383)
                                                  : $urandom_range(300));
            else if (p < 85)
                free_live();
            else if (p < 92)
                free_op($urandom_range(16383));
            else
                free_op(0);
        end
        while (live_blocks.size() != 0 && $urandom_range(1))
            free_live();
    endtask

    initial
    begin
        chunk_reg = CHUNK_RESET;
        brk_words = 4;
        heap_up = 1'b0;
        failed = 1'b0;
        cycle_count = 0;
        send_idle_pct = 37;
        recv_idle_pct = 74;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_chunk(4);
        test_random(150);
        write_chunk(8191);
        send_idle_pct = 74;
        recv_idle_pct = 37;
        test_random(150);
        write_chunk(0);
        test_random(100);
        write_chunk(4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100);
        write_chunk(63);
        test_random(100);
        drain();
        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
